// File: design/dtfp_pkg.sv
package dtfp_pkg;

   // Default number formats
   localparam int INT_BITS_DEFAULT      = 16;
   localparam int FRAC_BITS_DEFAULT     = 16;
   localparam int FRAC_ACC_BITS_DEFAULT = 24;

   // Fixed field widths of the channels
   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 32;

   // Fraction digit weights are kept as a table indexed by the digit position.
   // At the default widths the last entry is zero, so the index simply saturates there.
   localparam int WEIGHT_DEPTH      = 16;
   localparam int WEIGHT_INDEX_BITS = $clog2(WEIGHT_DEPTH);

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

   // Input item: one character of text, or the terminator.
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  is_end;
   } req_payload_type;

   // Result item: the parsed number and its status flags.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          overflow;
      logic                          bad_character;
   } rsp_payload_type;

   // Weight of the fraction digit at a given position, in Q0.acc_bits.
   // The first weight is one tenth, rounded; each later one is the previous
   // one divided by ten with rounding.
   function automatic logic [63:0] frac_weight(input int acc_bits, input int index);
      logic [63:0] weight;
      weight = ((64'd1 << acc_bits) + 64'd5) / 64'd10;
      for (int i = 0; i < WEIGHT_DEPTH; i++) begin
         if (i < index) begin
            weight = (weight + 64'd5) / 64'd10;
         end
      end
      return weight;
   endfunction

endpackage

// File: design/dtfp_stream_if.sv
interface dtfp_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: design/decimal_text_to_fixed_point.sv
// Decimal text to signed Q16.16 fixed point.
//
// Characters of a decimal number arrive on req_chan, one per transfer, and
// a transfer with is_end set closes the number. For each such terminator
// one result goes out on rsp_chan: the value in two's complement with
// FRAC_BITS fraction bits, an overflow flag for saturation and a
// bad_character flag when an unexpected character cut the number short.
// Other characters produce no result.
//
// Every accepted character lands in an input register and is folded into
// the parse state when it leaves that register; a terminator instead loads
// the result register, which then offers the result. One character is taken
// in every cycle while input is not stalled.
//
// When the receiver stalls, the result register holds its item and the
// block keeps taking characters. Input stops only when a terminator sits in
// the input register while the result register still holds an untaken
// result. Synchronous reset empties both registers and returns the parser
// to its start: no sign, zero totals, waiting for leading whitespace.
module decimal_text_to_fixed_point #(
   parameter int INT_BITS      = dtfp_pkg::INT_BITS_DEFAULT,
   parameter int FRAC_BITS     = dtfp_pkg::FRAC_BITS_DEFAULT,
   parameter int FRAC_ACC_BITS = dtfp_pkg::FRAC_ACC_BITS_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   dtfp_stream_if.sink   req_chan,
   dtfp_stream_if.source rsp_chan
);
   import dtfp_pkg::*;

   // Parser phases
   localparam logic [1:0] PHASE_SPACE = 2'd0;
   localparam logic [1:0] PHASE_SIGN  = 2'd1;
   localparam logic [1:0] PHASE_INT   = 2'd2;
   localparam logic [1:0] PHASE_FRAC  = 2'd3;

   // Integer magnitude never exceeds 2^(INT_BITS-1) - 1.
   localparam int TOTAL_BITS = INT_BITS - 1;
   localparam int INT_SUM_BITS = TOTAL_BITS + 4;
   localparam logic [TOTAL_BITS-1:0] INT_LIMIT = '1;

   // Fraction accumulator plus digit times weight.
   localparam int FRAC_SUM_BITS = FRAC_ACC_BITS + 5;
   localparam logic [FRAC_ACC_BITS-1:0] ACC_MASK = '1;

   // Final magnitude, wide enough for the range checks.
   localparam int MAG_RAW  = TOTAL_BITS + FRAC_BITS + 1;
   localparam int MAG_BITS = (MAG_RAW > VALUE_WIDTH + 1) ? MAG_RAW : VALUE_WIDTH + 1;
   localparam logic [MAG_BITS-1:0] NEG_LIMIT = MAG_BITS'(1) << (VALUE_WIDTH - 1);
   localparam logic [MAG_BITS-1:0] POS_LIMIT = NEG_LIMIT - MAG_BITS'(1);

   // Alignment of the fraction accumulator to the output format.
   localparam int ROUND_SH = (FRAC_ACC_BITS > FRAC_BITS) ? FRAC_ACC_BITS - FRAC_BITS : 0;
   localparam int LEFT_SH  = (FRAC_BITS > FRAC_ACC_BITS) ? FRAC_BITS - FRAC_ACC_BITS : 0;
   localparam int HALF_SH  = (ROUND_SH > 0) ? ROUND_SH - 1 : 0;
   localparam logic [MAG_BITS-1:0] ROUND_HALF = (ROUND_SH > 0) ? (MAG_BITS'(1) << HALF_SH) : '0;

   localparam logic [WEIGHT_INDEX_BITS-1:0] WEIGHT_LAST = WEIGHT_INDEX_BITS'(WEIGHT_DEPTH - 1);

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [CHAR_WIDTH-1:0] s1_char_ff;
   logic                  s1_end_ff;
   logic                  s1_advance;
   logic                  req_accept;

   // Parse state
   logic [1:0]                   phase_ff, phase_in;
   logic                         negative_ff, negative_in;
   logic [TOTAL_BITS-1:0]        int_total_ff, int_total_in;
   logic [FRAC_ACC_BITS-1:0]     frac_total_ff, frac_total_in;
   logic [WEIGHT_INDEX_BITS-1:0] weight_index_ff, weight_index_in;
   logic                         overflow_seen_ff, overflow_seen_in;
   logic                         bad_seen_ff, bad_seen_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Character decode and arithmetic
   logic                     is_digit, is_space, is_sign;
   logic [3:0]               digit_value;
   logic [CHAR_WIDTH-1:0]    digit_offset;
   logic [INT_SUM_BITS-1:0]  int_sum;
   logic                     int_sat;
   logic [FRAC_ACC_BITS-1:0] weight_table [WEIGHT_DEPTH];
   logic [FRAC_ACC_BITS-1:0] weight_now;
   logic [FRAC_SUM_BITS-1:0] frac_sum;
   logic                     frac_sat;
   logic                     take_int, take_frac;

   // Result arithmetic
   logic [MAG_BITS-1:0] frac_aligned;
   logic [MAG_BITS-1:0] magnitude;
   logic [MAG_BITS-1:0] mag_clamped;
   logic                mag_sat;

   // Handshake: the input register moves on unless it holds a terminator
   // and the result register is full and not being taken.
   assign s1_advance     = s1_valid_ff && (!s1_end_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff <= req_chan.payload.character;
         s1_end_ff  <= req_chan.payload.is_end;
      end
   end

   // Character classes.
   assign is_digit     = (s1_char_ff >= CHAR_ZERO) && (s1_char_ff <= CHAR_NINE);
   assign is_space     = ((s1_char_ff >= CHAR_TAB) && (s1_char_ff <= CHAR_CR))
                         || (s1_char_ff == CHAR_SPACE);
   assign is_sign      = (s1_char_ff == CHAR_PLUS) || (s1_char_ff == CHAR_MINUS);
   assign digit_offset = s1_char_ff - CHAR_ZERO;
   assign digit_value  = digit_offset[3:0];

   // Integer part: total times ten plus digit, built from two shifts.
   assign int_sum = (INT_SUM_BITS'(int_total_ff) << 3) + (INT_SUM_BITS'(int_total_ff) << 1)
                    + INT_SUM_BITS'(digit_value);
   assign int_sat = int_sum > INT_SUM_BITS'(INT_LIMIT);

   // Constant table of fraction digit weights.
   for (genvar g = 0; g < WEIGHT_DEPTH; g++) begin : g_weight
      assign weight_table[g] = FRAC_ACC_BITS'(frac_weight(FRAC_ACC_BITS, g));
   end

   assign weight_now = weight_table[weight_index_ff];
   assign frac_sum   = FRAC_SUM_BITS'(frac_total_ff)
                       + FRAC_SUM_BITS'(digit_value) * FRAC_SUM_BITS'(weight_now);
   assign frac_sat   = frac_sum > FRAC_SUM_BITS'(ACC_MASK);

   // Parser: one character per cycle while the input register advances; a terminator restarts it.
   always_comb begin
      phase_in         = phase_ff;
      negative_in      = negative_ff;
      int_total_in     = int_total_ff;
      frac_total_in    = frac_total_ff;
      weight_index_in  = weight_index_ff;
      overflow_seen_in = overflow_seen_ff;
      bad_seen_in      = bad_seen_ff;
      take_int         = 1'b0;
      take_frac        = 1'b0;

      if (s1_advance && s1_end_ff) begin
         phase_in         = PHASE_SPACE;
         negative_in      = 1'b0;
         int_total_in     = '0;
         frac_total_in    = '0;
         weight_index_in  = '0;
         overflow_seen_in = 1'b0;
         bad_seen_in      = 1'b0;
      end else if (s1_advance && !bad_seen_ff) begin
         unique case (phase_ff) inside
            PHASE_SPACE, PHASE_SIGN: begin
               if ((phase_ff == PHASE_SPACE) && is_space) begin
                  phase_in = PHASE_SPACE;
               end else if (is_sign) begin
                  if (s1_char_ff == CHAR_MINUS) begin
                     negative_in = !negative_ff;
                  end
                  phase_in = PHASE_SIGN;
               end else if (is_digit) begin
                  phase_in = PHASE_INT;
                  take_int = 1'b1;
               end else if (s1_char_ff == CHAR_DOT) begin
                  phase_in = PHASE_FRAC;
               end else begin
                  bad_seen_in = 1'b1;
               end
            end
            PHASE_INT: begin
               if (is_digit) begin
                  take_int = 1'b1;
               end else if (s1_char_ff == CHAR_DOT) begin
                  phase_in = PHASE_FRAC;
               end else begin
                  bad_seen_in = 1'b1;
               end
            end
            PHASE_FRAC: begin
               if (is_digit) begin
                  take_frac = 1'b1;
               end else begin
                  bad_seen_in = 1'b1;
               end
            end
            default: begin
               bad_seen_in = bad_seen_ff;
            end
         endcase

         // Digit accumulation with saturation.
         if (take_int) begin
            int_total_in = int_sat ? INT_LIMIT : int_sum[TOTAL_BITS-1:0];
            if (int_sat) begin
               overflow_seen_in = 1'b1;
            end
         end
         if (take_frac) begin
            frac_total_in = frac_sat ? ACC_MASK : frac_sum[FRAC_ACC_BITS-1:0];
            if (weight_index_ff != WEIGHT_LAST) begin
               weight_index_in = weight_index_ff + WEIGHT_INDEX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_SPACE;
         negative_ff      <= 1'b0;
         int_total_ff     <= '0;
         frac_total_ff    <= '0;
         weight_index_ff  <= '0;
         overflow_seen_ff <= 1'b0;
         bad_seen_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         negative_ff      <= negative_in;
         int_total_ff     <= int_total_in;
         frac_total_ff    <= frac_total_in;
         weight_index_ff  <= weight_index_in;
         overflow_seen_ff <= overflow_seen_in;
         bad_seen_ff      <= bad_seen_in;
      end
   end

   // Final value: align the fraction, add the integer part, apply the sign
   // and clamp to the signed output range.
   assign frac_aligned = ((MAG_BITS'(frac_total_ff) + ROUND_HALF) >> ROUND_SH) << LEFT_SH;
   assign magnitude    = (MAG_BITS'(int_total_ff) << FRAC_BITS) + frac_aligned;

   always_comb begin
      if (negative_ff) begin
         mag_sat     = magnitude > NEG_LIMIT;
         mag_clamped = mag_sat ? NEG_LIMIT : magnitude;
         rsp_payload_in.value = VALUE_WIDTH'(MAG_BITS'(0) - mag_clamped);
      end else begin
         mag_sat     = magnitude > POS_LIMIT;
         mag_clamped = mag_sat ? POS_LIMIT : magnitude;
         rsp_payload_in.value = VALUE_WIDTH'(mag_clamped);
      end
      rsp_payload_in.overflow      = overflow_seen_ff || mag_sat;
      rsp_payload_in.bad_character = bad_seen_ff;
   end

   // Result register: loaded by a terminator, emptied by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_end_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_end_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

// File: design/dtfp_checker.sv
module dtfp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_is_end,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dtfp_pkg::VALUE_WIDTH-1:0] rsp_value,
   input logic                            rsp_overflow,
   input logic                            rsp_bad_character
);

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
                                  && $stable(rsp_overflow) && $stable(rsp_bad_character))
   else $error("stalled result changed or was dropped");

   // Reset leaves no result behind.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("result offered right after reset");

   // A new result must follow a terminator transfer that passed through the
   // input register and then loaded the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_is_end, 2))
   else $error("result without a matching terminator transfer");

   // Input is held back only by a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
   else $error("input stalled while the output side was free");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_is_end        (req_chan.payload.is_end),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_value         (rsp_chan.payload.value),
   .rsp_overflow      (rsp_chan.payload.overflow),
   .rsp_bad_character (rsp_chan.payload.bad_character)
);
